// ----- hw/rtl/pfs_pkg.sv -----
`timescale 1ns / 1ps

package pfs_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int OVERHEAD_DEF   = 104;
  localparam int BYTE_TOT_W     = 21;
  localparam int TIME_TOT_W     = 21;
  localparam int QCOUNT_W       = 5;
  localparam int QTIME_W        = 20;
  localparam int RES_DEPTH      = 4;
  localparam int RES_AW         = 2;

  typedef enum logic [2:0] {
    OP_PUT    = 3'd0,
    OP_MARK   = 3'd1,
    OP_GET    = 3'd2,
    OP_START  = 3'd3,
    OP_ABORT  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_DEQ     = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ABORTED = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] pkt_ref;
    logic [15:0] pkt_bytes;
    logic [15:0] pkt_time;
    logic        wait_empty;
  } item_t;

  typedef struct packed {
    logic [31:0] pkt_ref;
    logic [15:0] pkt_bytes;
    logic [15:0] pkt_time;
    logic [15:0] serial;
    logic        marker;
  } entry_t;

  typedef struct packed {
    status_t                 status;
    logic [31:0]             out_ref;
    logic [15:0]             out_bytes;
    logic [15:0]             out_time;
    logic                    out_is_marker;
    logic [15:0]             out_serial;
    logic [QCOUNT_W-1:0]     queue_count;
    logic [BYTE_TOT_W-1:0]   queue_bytes;
    logic [QTIME_W-1:0]      queue_time;
    logic [15:0]             serial_now;
    logic                    is_aborted;
    logic                    last;
  } res_t;

endpackage

// ----- hw/rtl/pfs_ram.sv -----
`timescale 1ns / 1ps

module pfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/pfs_core.sv -----
`timescale 1ns / 1ps

module pfs_core #(
  parameter int DEPTH          = pfs_pkg::DEPTH_DEF,
  parameter int ENTRY_OVERHEAD = pfs_pkg::OVERHEAD_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  pfs_pkg::item_t item,
  output logic [1:0]     n_beats,
  output pfs_pkg::res_t  beat0,
  output pfs_pkg::res_t  beat1
);
  import pfs_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [AW-1:0]          head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [BYTE_TOT_W-1:0]  bytes_r, bytes_nxt;
  logic [TIME_TOT_W-1:0]  time_r, time_nxt;
  logic [15:0]            gen_r, gen_nxt;
  logic                   abort_r, abort_nxt;
  logic                   held_r, held_nxt;

  logic                   byp_v_r;
  entry_t                 byp_d_r;
  entry_t                 ram_q, head_e, new_e;
  logic                   wr_en;

  op_t                    op;
  logic                   is_put, is_marker, abort_eff, push_ok, serve, do_pop;
  status_t                st0, st1;
  entry_t                 pop_e0, pop_e1;
  logic                   pop0, pop1;
  res_t                   b0, b1;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  pfs_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (new_e),
    .rd_addr (head_nxt),
    .rd_data (ram_q)
  );

  // entry written at the edge it was read sits in the bypass register
  assign head_e = byp_v_r ? byp_d_r : ram_q;

  always_comb begin
    op        = op_t'(item.op);
    is_put    = (op == OP_PUT) || (op == OP_MARK) || (op == OP_START);
    is_marker = (op != OP_PUT);
    abort_eff = (op == OP_START) ? 1'b0 : abort_r;
    push_ok   = step && is_put && !abort_eff && (count_r < CNT_W'(DEPTH));
    serve     = push_ok && held_r;

    gen_nxt = (push_ok && is_marker) ? gen_r + 16'd1 : gen_r;

    new_e.pkt_ref   = is_marker ? 32'd0 : item.pkt_ref;
    new_e.pkt_bytes = is_marker ? 16'd0 : item.pkt_bytes;
    new_e.pkt_time  = is_marker ? 16'd0 : item.pkt_time;
    new_e.serial    = gen_nxt;
    new_e.marker    = is_marker;

    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    bytes_nxt = bytes_r;
    time_nxt  = time_r;
    abort_nxt = abort_r;
    held_nxt  = held_r;
    wr_en     = 1'b0;
    do_pop    = 1'b0;

    n_beats = 2'd1;
    st0     = ST_DONE;
    st1     = ST_DONE;
    pop0    = 1'b0;
    pop1    = 1'b0;

    case (op)
      OP_PUT, OP_MARK, OP_START: begin
        if (op == OP_START) begin
          abort_nxt = 1'b0;
        end
        if (abort_eff) begin
          st0 = ST_ABORTED;
        end else if (!push_ok) begin
          st0 = ST_FULL;
        end else if (serve) begin
          // the held get takes the new entry straight away
          held_nxt = 1'b0;
          head_nxt = next_slot(head_r);
          tail_nxt = next_slot(tail_r);
          n_beats  = 2'd2;
          st1      = ST_DEQ;
          pop1     = 1'b1;
        end else begin
          wr_en     = step;
          tail_nxt  = next_slot(tail_r);
          count_nxt = count_r + CNT_W'(1);
          bytes_nxt = bytes_r + BYTE_TOT_W'(new_e.pkt_bytes)
                      + BYTE_TOT_W'(ENTRY_OVERHEAD);
          time_nxt  = time_r + TIME_TOT_W'(new_e.pkt_time);
        end
      end
      OP_GET: begin
        if (abort_r) begin
          st0 = ST_ABORTED;
        end else if (count_r != '0) begin
          do_pop = 1'b1;
          st0    = ST_DEQ;
          pop0   = 1'b1;
        end else if (item.wait_empty && !held_r) begin
          held_nxt = 1'b1;
          n_beats  = 2'd0;
        end else begin
          st0 = ST_EMPTY;
        end
      end
      OP_ABORT: begin
        abort_nxt = 1'b1;
        if (held_r) begin
          held_nxt = 1'b0;
          n_beats  = 2'd2;
          st1      = ST_ABORTED;
        end
      end
      OP_CLEAR: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
        bytes_nxt = '0;
        time_nxt  = '0;
      end
      default: begin
        st0 = ST_DONE;
      end
    endcase

    if (do_pop) begin
      head_nxt  = next_slot(head_r);
      count_nxt = count_r - CNT_W'(1);
      bytes_nxt = bytes_r - BYTE_TOT_W'(head_e.pkt_bytes) - BYTE_TOT_W'(ENTRY_OVERHEAD);
      time_nxt  = time_r - TIME_TOT_W'(head_e.pkt_time);
    end

    if (!step) begin
      head_nxt  = head_r;
      tail_nxt  = tail_r;
      count_nxt = count_r;
      bytes_nxt = bytes_r;
      time_nxt  = time_r;
      gen_nxt   = gen_r;
      abort_nxt = abort_r;
      held_nxt  = held_r;
      n_beats   = 2'd0;
    end

    pop_e0 = pop0 ? head_e : '0;
    pop_e1 = pop1 ? new_e : '0;

    b0.status        = st0;
    b0.out_ref       = pop_e0.pkt_ref;
    b0.out_bytes     = pop_e0.pkt_bytes;
    b0.out_time      = pop_e0.pkt_time;
    b0.out_is_marker = pop_e0.marker;
    b0.out_serial    = pop_e0.serial;
    b0.queue_count   = QCOUNT_W'(count_nxt);
    b0.queue_bytes   = bytes_nxt;
    b0.queue_time    = time_nxt[QTIME_W-1:0];
    b0.serial_now    = gen_nxt;
    b0.is_aborted    = abort_nxt;
    b0.last          = (n_beats == 2'd1);

    b1               = b0;
    b1.status        = st1;
    b1.out_ref       = pop_e1.pkt_ref;
    b1.out_bytes     = pop_e1.pkt_bytes;
    b1.out_time      = pop_e1.pkt_time;
    b1.out_is_marker = pop_e1.marker;
    b1.out_serial    = pop_e1.serial;
    b1.last          = 1'b1;
  end

  assign beat0 = b0;
  assign beat1 = b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      bytes_r <= '0;
      time_r  <= '0;
      gen_r   <= '0;
      abort_r <= 1'b1;
      held_r  <= 1'b0;
      byp_v_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      bytes_r <= bytes_nxt;
      time_r  <= time_nxt;
      gen_r   <= gen_nxt;
      abort_r <= abort_nxt;
      held_r  <= held_nxt;
      byp_v_r <= wr_en && (tail_r == head_nxt);
    end
  end

  always_ff @(posedge clk) begin
    byp_d_r <= new_e;
  end

endmodule

// ----- hw/rtl/pfs_res_fifo.sv -----
`timescale 1ns / 1ps

module pfs_res_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    wr_n,
  input  pfs_pkg::res_t wr0,
  input  pfs_pkg::res_t wr1,
  output logic          room2,
  output logic          rd_valid,
  input  logic          rd_ready,
  output pfs_pkg::res_t rd_data
);
  import pfs_pkg::*;

  localparam int CW = RES_AW + 1;

  res_t              buf_r [RES_DEPTH];
  logic [RES_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pop;

  assign room2    = (cnt_r <= CW'(RES_DEPTH - 2));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = buf_r[rp_r];
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r + RES_AW'(wr_n);
    rp_nxt  = pop ? rp_r + RES_AW'(1) : rp_r;
    cnt_nxt = cnt_r + CW'(wr_n) - (pop ? CW'(1) : CW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      buf_r[wp_r] <= wr0;
    end
    if (wr_n == 2'd2) begin
      buf_r[wp_r + RES_AW'(1)] <= wr1;
    end
  end

endmodule

// ----- hw/rtl/packet_fifo_with_serial_core.sv -----
`timescale 1ns / 1ps

// channel   dir   handshake           tdata / tuser / tlast
// in_       in    in_tvalid/tready    tdata 72b descriptor, tuser 3b operation
// out_      out   out_tvalid/tready   tdata 144b entry and queue state, tuser status,
//                                     tlast on final beat of an operation
//
// an accepted beat is held in the input register, where the queue
// update and its result beats are formed; they land in a four-deep
// result buffer; one operation per cycle is sustained while it has room.
// the result buffer must hold room for two beats before an operation goes
// through, so a stalled out_ side holds in_tready low once a beat waits in
// the input register and three or four result beats are waiting.
// the head descriptor is prefetched from the ring memory at the next head address.
// reset (rst_n low, synchronous) empties the queue, zeroes the serial and
// leaves the queue aborted until a start.

module packet_fifo_with_serial_core #(
  parameter int DEPTH          = pfs_pkg::DEPTH_DEF,
  parameter int ENTRY_OVERHEAD = pfs_pkg::OVERHEAD_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // packet_ref[31:0], packet_bytes[47:32], packet_time[63:48],
  // wait_if_empty[64], zero pad[71:65]
  input  logic [71:0]  in_tdata,
  // operation[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_ref[31:0], out_bytes[47:32], out_time[63:48], out_is_marker[64],
  // out_serial[80:65], queue_count[85:81], queue_bytes[106:86],
  // queue_time[126:107], serial_now[142:127], is_aborted[143]
  output logic [143:0] out_tdata,
  // status[2:0]
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);
  import pfs_pkg::*;

  logic   in_v_r;
  item_t  item_r;
  logic   room2, step;
  logic [1:0] n_beats;
  res_t   beat0, beat1, res_q;

  assign step      = in_v_r && room2;
  assign in_tready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.op         <= in_tuser;
      item_r.pkt_ref    <= in_tdata[31:0];
      item_r.pkt_bytes  <= in_tdata[47:32];
      item_r.pkt_time   <= in_tdata[63:48];
      item_r.wait_empty <= in_tdata[64];
    end
  end

  pfs_core #(
    .DEPTH          (DEPTH),
    .ENTRY_OVERHEAD (ENTRY_OVERHEAD)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .item    (item_r),
    .n_beats (n_beats),
    .beat0   (beat0),
    .beat1   (beat1)
  );

  pfs_res_fifo u_res (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_n     (n_beats),
    .wr0      (beat0),
    .wr1      (beat1),
    .room2    (room2),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (res_q)
  );

  assign out_tuser = res_q.status;
  assign out_tlast = res_q.last;
  assign out_tdata = {res_q.is_aborted, res_q.serial_now, res_q.queue_time,
                      res_q.queue_bytes, res_q.queue_count, res_q.out_serial,
                      res_q.out_is_marker, res_q.out_time, res_q.out_bytes,
                      res_q.out_ref};

endmodule
